[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the quadrature decoder.
// Uses clk and rst_n from the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(lbl, trig, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, trig, expr)
`endif
`endif

[sv/qed_pkg.sv]
// Types, codes and the phase transition table of the quadrature decoder.
// No dependencies.
package qed_pkg;

  localparam int PIN_W   = 8;
  localparam int IDX_W   = 2;
  localparam int DIR_W   = 2;
  localparam int PHASE_W = 4;
  localparam int CODE_W  = 8;

  typedef logic [PIN_W-1:0]   pins_t;
  typedef logic [IDX_W-1:0]   enc_idx_t;
  typedef logic [DIR_W-1:0]   dir_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [CODE_W-1:0]  code_t;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_CW   = 2'd1;
  localparam dir_t DIR_CCW  = 2'd2;

  localparam code_t CODE_CW  = 8'hF0;
  localparam code_t CODE_CCW = 8'h0F;

  // Transition table; rows without an entry lead to phase 0 with no step.
  function automatic code_t step_code(input phase_t phase, input logic [1:0] pair);
    code_t code;
    code = 8'h00;
    case ({phase, pair})
      6'b0000_01: code = 8'h01;
      6'b0000_10: code = 8'h08;
      6'b0001_01: code = 8'h01;
      6'b0001_11: code = 8'h03;
      6'b0010_00: code = CODE_CCW;
      6'b0010_10: code = 8'h02;
      6'b0010_11: code = 8'h03;
      6'b0011_01: code = 8'h01;
      6'b0011_10: code = 8'h02;
      6'b0011_11: code = 8'h03;
      6'b0100_00: code = CODE_CW;
      6'b0100_01: code = 8'h04;
      6'b0100_11: code = 8'h0C;
      6'b1000_10: code = 8'h08;
      6'b1000_11: code = 8'h0C;
      6'b1100_01: code = 8'h04;
      6'b1100_10: code = 8'h08;
      6'b1100_11: code = 8'h0C;
      default:    code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

[sv/quad_encoder_decoder.sv]
// Quadrature decoder for up to four two-bit rotary encoders.
// Depends on qed_pkg and assert_macros.svh.
//
// Input channel: in_valid / in_stall carries one pin byte (in_pin_levels),
// encoder k on bits 2k and 2k+1. Result channel: out_valid / out_stall
// carries one result per byte: out_encoder_index and out_direction
// (0 none, 1 clockwise, 2 counter-clockwise; index 0 when none).
// A transfer happens at a rising edge with valid high and stall low.
// With the result register free, a byte's result is offered from the cycle
// after it is accepted. Throughput is one byte per cycle while in_stall is
// low; the decode is a single table lookup between the pin/phase registers and the result
// register. A two-entry output stage (result register plus skid register)
// lets a byte be accepted while a result waits; in_stall rises only once
// both entries are full, and it is a register, so out_stall never reaches
// in_stall combinationally. While the receiver stalls, out_* hold.
// Reset (rst_n low, synchronous) clears the previous pins, every encoder
// phase and both output entries; in_stall is high during reset.
module quad_encoder_decoder #(
  parameter int NUM_ENCODERS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qed_pkg::pins_t    in_pin_levels,
  output logic              out_valid,
  input  logic              out_stall,
  output qed_pkg::enc_idx_t out_encoder_index,
  output qed_pkg::dir_t     out_direction
);
  import qed_pkg::*;

  pins_t    prev_r;
  phase_t   phase_r [NUM_ENCODERS];
  phase_t   phase_nxt [NUM_ENCODERS];

  logic     out_valid_r;
  enc_idx_t out_idx_r;
  dir_t     out_dir_r;
  logic     skid_valid_r;
  enc_idx_t skid_idx_r;
  dir_t     skid_dir_r;

  enc_idx_t idx_nxt;
  dir_t     dir_nxt;
  pins_t    changed;
  logic     accept;
  logic     out_free;

  assign in_stall = skid_valid_r || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign changed  = in_pin_levels ^ prev_r;

  // Advance only the lowest encoder whose pins changed.
  always_comb begin
    logic   found;
    code_t  code;
    found   = 1'b0;
    code    = '0;
    idx_nxt = '0;
    dir_nxt = DIR_NONE;
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      phase_nxt[k] = phase_r[k];
    end
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      if (!found && (changed[2*k +: 2] != 2'b00)) begin
        found = 1'b1;
        code  = step_code(phase_r[k], in_pin_levels[2*k +: 2]);
        if (code == CODE_CW) begin
          phase_nxt[k] = '0;
          idx_nxt      = IDX_W'(k);
          dir_nxt      = DIR_CW;
        end else if (code == CODE_CCW) begin
          phase_nxt[k] = '0;
          idx_nxt      = IDX_W'(k);
          dir_nxt      = DIR_CCW;
        end else begin
          phase_nxt[k] = code[PHASE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      for (int k = 0; k < NUM_ENCODERS; k++) begin
        phase_r[k] <= '0;
      end
    end else if (accept) begin
      prev_r <= in_pin_levels;
      for (int k = 0; k < NUM_ENCODERS; k++) begin
        phase_r[k] <= phase_nxt[k];
      end
    end
  end

  // Output stage: result register fed from the skid entry first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_idx_r <= skid_idx_r;
        out_dir_r <= skid_dir_r;
      end else if (accept) begin
        out_idx_r <= idx_nxt;
        out_dir_r <= dir_nxt;
      end
    end else if (accept) begin
      skid_idx_r <= idx_nxt;
      skid_dir_r <= dir_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_encoder_index = out_idx_r;
  assign out_direction     = out_dir_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r)
  `ASSERT_ALWAYS(a_dir_code, !out_valid_r || (out_dir_r != 2'd3))
  `ASSERT_ALWAYS(a_idle_index, !out_valid_r || (out_dir_r != DIR_NONE) || (out_idx_r == '0))
  `ASSERT_NEXT(a_accept_lands, accept, out_valid_r)
  `ASSERT_NEXT(a_step_idles_enc0, accept && (dir_nxt != DIR_NONE) && (idx_nxt == '0), phase_r[0] == '0)
  `ASSERT_ALWAYS(a_phase_row, phase_r[0] < 4'd13)

endmodule

[tb/sv/quad_encoder_decoder_tb.sv]
// Self-checking testbench for quad_encoder_decoder: directed pin sequences, then
// random Gray-code walks with noise, checked against a behavioural phase decoder.
// Depends on qed_pkg and the RTL of quad_encoder_decoder.
module quad_encoder_decoder_tb;
  import qed_pkg::*;

  localparam int ENC_COUNT   = 4;
  localparam int RAND_ITEMS  = 1850;
  localparam int BURST_LEN   = 40;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    enc_idx_t idx;
    dir_t     dir;
  } step_report_t;

  typedef struct packed {
    pins_t        pins;
    logic         fixed;
    step_report_t want;
  } pin_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pins_t    in_pin_levels;
  logic     out_valid;
  logic     out_stall;
  enc_idx_t out_encoder_index;
  dir_t     out_direction;

  // Predictor state
  pins_t  last_pins;
  phase_t enc_phase [ENC_COUNT];

  step_report_t pending_steps[$];
  pin_row_t     pin_rows[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  logic         tx_burst = 1'b0;
  logic         rx_burst = 1'b0;
  logic         turn_cw [ENC_COUNT];

  quad_encoder_decoder #(.NUM_ENCODERS(ENC_COUNT)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_encoder_index(out_encoder_index),
    .out_direction    (out_direction)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Row of the phase table, packed as {pair 3, pair 2, pair 1, pair 0}
  function automatic code_t phase_code(input phase_t phase, input logic [1:0] pair);
    logic [31:0] row;
    case (phase)
      4'd0:    row = {8'h00, 8'h08, 8'h01, 8'h00};
      4'd1:    row = {8'h03, 8'h00, 8'h01, 8'h00};
      4'd2:    row = {8'h03, 8'h02, 8'h00, 8'h0F};
      4'd3:    row = {8'h03, 8'h02, 8'h01, 8'h00};
      4'd4:    row = {8'h0C, 8'h00, 8'h04, 8'hF0};
      4'd8:    row = {8'h0C, 8'h08, 8'h00, 8'h00};
      4'd12:   row = {8'h0C, 8'h08, 8'h04, 8'h00};
      default: row = 32'h0;
    endcase
    return row[8*pair +: 8];
  endfunction

  // Advance the lowest encoder whose pins moved; drop changes above it
  function automatic step_report_t decode_pins(input pins_t pins);
    step_report_t rep;
    pins_t        changed;
    code_t        code;
    logic         found;
    rep.idx = '0;
    rep.dir = DIR_NONE;
    changed = pins ^ last_pins;
    last_pins = pins;
    found = 1'b0;
    for (int k = 0; k < ENC_COUNT; k++) begin
      if (!found && changed[2*k +: 2] != 2'b00) begin
        found = 1'b1;
        code = phase_code(enc_phase[k], pins[2*k +: 2]);
        if (code == CODE_CW) begin
          enc_phase[k] = '0;
          rep.idx = k[IDX_W-1:0];
          rep.dir = DIR_CW;
        end else if (code == CODE_CCW) begin
          enc_phase[k] = '0;
          rep.idx = k[IDX_W-1:0];
          rep.dir = DIR_CCW;
        end else begin
          enc_phase[k] = code[PHASE_W-1:0];
        end
      end
    end
    return rep;
  endfunction

  // Next pin pair along a Gray walk: clockwise 00 10 11 01, counter-clockwise reversed
  function automatic logic [1:0] gray_next(input logic [1:0] pair, input logic cw);
    logic [1:0] nxt;
    case (pair)
      2'b00:   nxt = cw ? 2'b10 : 2'b01;
      2'b10:   nxt = cw ? 2'b11 : 2'b00;
      2'b11:   nxt = cw ? 2'b01 : 2'b10;
      default: nxt = cw ? 2'b00 : 2'b11;
    endcase
    return nxt;
  endfunction

  function automatic pins_t random_pins(input pins_t cur);
    pins_t nxt;
    int    pick;
    int    k;
    pins_t upper;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, ENC_COUNT - 1);
    if ($urandom_range(0, 19) == 0)
      turn_cw[k] = !turn_cw[k];
    nxt = cur;
    nxt[2*k +: 2] = gray_next(cur[2*k +: 2], turn_cw[k]);
    if (pick >= 70 && pick < 85) begin
      // Disturb encoders above the one that steps
      upper = pins_t'(8'hFF << (2*k + 2));
      nxt = nxt ^ (pins_t'($urandom) & upper);
    end else if (pick >= 85 && pick < 95) begin
      nxt = pins_t'($urandom_range(0, 255));
    end else if (pick >= 95) begin
      nxt = cur;
    end
    return nxt;
  endfunction

  function automatic void add_row(input pins_t pins, input logic fixed,
                                  input enc_idx_t idx, input dir_t dir);
    pin_row_t row;
    row.pins = pins;
    row.fixed = fixed;
    row.want.idx = idx;
    row.want.dir = dir;
    pin_rows.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_pins(input pins_t pins, input logic fixed, input step_report_t want);
    int           gap;
    step_report_t got;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pin_levels <= pins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = decode_pins(pins);
    pending_steps.push_back(fixed ? want : got);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_steps.size() != 0) @(negedge clk);
  endtask

  // Result side: hold stall for a random count, then take one transfer
  initial begin
    int hold;
    int taken;
    taken = 0;
    out_stall = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      hold = rx_burst ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % BURST_LEN == 0)
        rx_burst = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    step_report_t exp_rep;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result: encoder_index %0d direction %0d",
               out_encoder_index, out_direction);
        mismatches++;
      end else begin
        exp_rep = pending_steps.pop_front();
        if (out_encoder_index !== exp_rep.idx) begin
          $error("encoder_index: expected %0d, actual %0d", exp_rep.idx, out_encoder_index);
          mismatches++;
        end
        if (out_direction !== exp_rep.dir) begin
          $error("direction: expected %0d, actual %0d", exp_rep.dir, out_direction);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    pins_t        cur;
    step_report_t none_rep;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pin_levels = '0;
    last_pins = '0;
    for (int k = 0; k < ENC_COUNT; k++) begin
      enc_phase[k] = '0;
      turn_cw[k] = 1'($urandom_range(0, 1));
    end
    none_rep.idx = '0;
    none_rep.dir = DIR_NONE;

    // Idle after reset, then all pins high and low again
    add_row(8'h00, 1'b1, 2'd0, DIR_NONE);
    add_row(8'hFF, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h00, 1'b0, 2'd0, DIR_NONE);
    // Encoder 0 clockwise, then counter-clockwise
    add_row(8'h02, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h03, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h01, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h00, 1'b1, 2'd0, DIR_CW);
    add_row(8'h01, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h03, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h02, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h00, 1'b1, 2'd0, DIR_CCW);
    // Encoder 3 clockwise
    add_row(8'h80, 1'b0, 2'd0, DIR_NONE);
    add_row(8'hC0, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h40, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h00, 1'b1, 2'd3, DIR_CW);
    // Encoder 1 counter-clockwise while encoder 2 moves too: drop encoder 2
    add_row(8'h04, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h3C, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h28, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h00, 1'b1, 2'd1, DIR_CCW);
    // Encoder 2 clockwise from its untouched idle phase
    add_row(8'h20, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h30, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h10, 1'b0, 2'd0, DIR_NONE);
    add_row(8'h00, 1'b1, 2'd2, DIR_CW);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (pin_rows[i])
      send_pins(pin_rows[i].pins, pin_rows[i].fixed, pin_rows[i].want);
    in_valid <= 1'b0;
    drain_results();

    cur = 8'h00;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % BURST_LEN == 0)
        tx_burst = ($urandom_range(0, 2) == 0);
      if (i == RAND_ITEMS / 2) begin
        // Hold off until every outstanding result has come back
        in_valid <= 1'b0;
        drain_results();
      end
      cur = random_pins(cur);
      send_pins(cur, 1'b0, none_rep);
    end
    in_valid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/qed_pkg.sv
sv/quad_encoder_decoder.sv
tb/sv/quad_encoder_decoder_tb.sv
